### rtl/icfm_pkg.sv
package icfm_pkg;

  // Width of the free-running capture counter.
  localparam int unsigned CounterWidth = 16;
  // Width of a capture value as delivered by the timer.
  localparam int unsigned CaptureWidth = 16;
  // Width of the timer clock register and of the frequency result.
  localparam int unsigned ClockWidth   = 28;
  // One quotient bit is resolved per divider step.
  localparam int unsigned DivSteps     = ClockWidth;
  localparam int unsigned StepCntWidth = $clog2(DivSteps + 1);

  localparam logic [ClockWidth-1:0] ClockReset = ClockWidth'(72000000);

  typedef struct packed {
    logic                    start;
    logic [ClockWidth-1:0]   dividend;
    logic [CounterWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [ClockWidth-1:0] quotient;
  } div_status_t;

  typedef enum logic [2:0] {
    StIdle    = 3'b001,
    StDivide  = 3'b010,
    StDeliver = 3'b100
  } state_e;

endpackage

### rtl/icfm_capture_if.sv
interface icfm_capture_if;
  import icfm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CaptureWidth-1:0] capture_value;
  logic                    on_measured_channel;

  modport source (output valid, output capture_value, output on_measured_channel,
                  input ready);
  modport sink   (input valid, input capture_value, input on_measured_channel,
                  output ready);
endinterface

### rtl/icfm_result_if.sv
interface icfm_result_if;
  import icfm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ClockWidth-1:0] frequency_hz;
  logic                  equal_capture_error;

  modport source (output valid, output frequency_hz, output equal_capture_error,
                  input ready);
  modport sink   (input valid, input frequency_hz, input equal_capture_error,
                  output ready);
endinterface

### rtl/icfm_cfg_if.sv
interface icfm_cfg_if;
  import icfm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ClockWidth-1:0] timer_clock_hz;

  modport source (output valid, output timer_clock_hz, input ready);
  modport sink   (input valid, input timer_clock_hz, output ready);
endinterface

### rtl/icfm_divider.sv
// Restoring divider: one compare-and-subtract per cycle, one quotient bit per step.
module icfm_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  icfm_pkg::div_req_t    req_i,
  output icfm_pkg::div_status_t status_o
);
  import icfm_pkg::*;

  logic [StepCntWidth-1:0] count_q, count_d;
  logic [CounterWidth-1:0] rem_q, rem_d;
  logic [ClockWidth-1:0]   quo_q, quo_d;
  logic [CounterWidth-1:0] divisor_q, divisor_d;
  logic                    done_q, done_d;

  logic [CounterWidth:0]   trial;
  logic [CounterWidth:0]   diff;

  // The partial remainder with the next dividend bit shifted in.
  assign trial = {rem_q, quo_q[ClockWidth-1]};
  assign diff  = trial - {1'b0, divisor_q};

  always_comb begin
    count_d   = count_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    divisor_d = divisor_q;
    done_d    = 1'b0;
    if (req_i.start) begin
      count_d   = StepCntWidth'(DivSteps);
      rem_d     = '0;
      quo_d     = req_i.dividend;
      divisor_d = req_i.divisor;
    end else if (count_q != '0) begin
      count_d = count_q - 1'b1;
      if (!diff[CounterWidth]) begin
        rem_d = diff[CounterWidth-1:0];
        quo_d = {quo_q[ClockWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[CounterWidth-1:0];
        quo_d = {quo_q[ClockWidth-2:0], 1'b0};
      end
      done_d = (count_q == StepCntWidth'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
  end

  assign status_o.done     = done_q;
  assign status_o.quotient = quo_q;

endmodule

### rtl/input_capture_frequency_meter.sv
// A second capture of a pair goes to the restoring divider, one quotient bit per
// step; the sequencer sees the divider finish and loads the output register once
// the output register is free. An equal pair skips the divider and goes to the
// output register as an error result. A first capture or one from another channel
// gives no result. Captures are taken only while idle, so not while a pair is busy.
// Reset (rst_ni, asynchronous, active low) empties the pairing and loads 72 MHz.
module input_capture_frequency_meter (
  input  logic           clk_i,
  input  logic           rst_ni,
  icfm_capture_if.sink   capture_i,
  icfm_cfg_if.sink       cfg_i,
  icfm_result_if.source  result_o
);
  import icfm_pkg::*;

  // Configuration register. Writes are only to be made while the block is idle; the
  // block does not enforce this, and it is always ready to take them.
  logic [ClockWidth-1:0] timer_clock_q;

  // Pairing state: whether a first capture is held, and its value.
  logic                    have_first_q, have_first_d;
  logic [CounterWidth-1:0] first_q, first_d;

  // Sequencer state and the flag telling the delivery step that the pair was equal.
  state_e state_q, state_d;
  logic   err_q, err_d;

  // Output register. It decouples the result request from the next capture.
  logic                  res_valid_q, res_valid_d;
  logic [ClockWidth-1:0] res_freq_q, res_freq_d;
  logic                  res_err_q, res_err_d;

  div_req_t    div_req;
  div_status_t div_status;

  logic                    cap_accept;
  logic [CounterWidth-1:0] cap_value;
  logic [CounterWidth-1:0] period;
  logic                    slot_free;

  assign cfg_i.ready = 1'b1;

  // Counter bits above the capture width are zero; capture bits above the counter
  // width are dropped.
  assign cap_value  = CounterWidth'(capture_i.capture_value);
  // Modular difference: when the counter has wrapped this equals 2^width minus
  // the first capture plus the second one.
  assign period     = cap_value - first_q;

  assign capture_i.ready = (state_q == StIdle);
  assign cap_accept      = capture_i.valid && capture_i.ready;
  assign slot_free       = !res_valid_q || result_o.ready;

  always_comb begin
    state_d      = state_q;
    have_first_d = have_first_q;
    first_d      = first_q;
    err_d        = err_q;
    res_valid_d  = res_valid_q;
    res_freq_d   = res_freq_q;
    res_err_d    = res_err_q;

    div_req.start    = 1'b0;
    div_req.dividend = timer_clock_q;
    div_req.divisor  = period;

    // A waiting result leaves the output register when it is taken.
    if (res_valid_q && result_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (cap_accept && capture_i.on_measured_channel) begin
          if (!have_first_q) begin
            have_first_d = 1'b1;
            first_d      = cap_value;
          end else begin
            // Second capture: the pair closes whatever its outcome.
            have_first_d = 1'b0;
            if (period == '0) begin
              err_d   = 1'b1;
              state_d = StDeliver;
            end else begin
              err_d         = 1'b0;
              div_req.start = 1'b1;
              state_d       = StDivide;
            end
          end
        end
      end
      StDivide: begin
        if (div_status.done) begin
          state_d = StDeliver;
        end
      end
      StDeliver: begin
        // Wait here until the previous result has been taken.
        if (slot_free) begin
          res_valid_d = 1'b1;
          res_freq_d  = err_q ? '0 : div_status.quotient;
          res_err_d   = err_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clock_q <= ClockReset;
      have_first_q  <= 1'b0;
      first_q       <= '0;
      state_q       <= StIdle;
      err_q         <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        timer_clock_q <= cfg_i.timer_clock_hz;
      end
      have_first_q <= have_first_d;
      first_q      <= first_d;
      state_q      <= state_d;
      err_q        <= err_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_freq_q <= res_freq_d;
    res_err_q  <= res_err_d;
  end

  // The divider; a zero timer clock naturally yields a zero quotient.
  icfm_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (div_req),
    .status_o (div_status)
  );

  assign result_o.valid               = res_valid_q;
  assign result_o.frequency_hz        = res_freq_q;
  assign result_o.equal_capture_error = res_err_q;

endmodule

### verif/input_capture_frequency_meter_tb.sv
`timescale 1ns / 1ps

module input_capture_frequency_meter_tb;
  import icfm_pkg::*;

  // Settling time after the last expected reading. A lone first edge or an
  // ignored request produces no reading, so allow for a full divide as well.
  localparam int unsigned SettleCycles = 40;
  // At set result counts in the run, the receiver holds off for this long while
  // the sender keeps offering requests, so the meter fills and back-pressures.
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned FirstHoldAt    = 30;
  localparam int unsigned HoldSpacing    = 270;
  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned PhaseEdges     = 120;
  localparam logic [ClockWidth-1:0] ClockMaxHz = ClockWidth'(200000000);

  // One capture request as offered to the meter.
  typedef struct packed {
    logic [CaptureWidth-1:0] value;
    logic                    measured;
  } capture_t;

  // One frequency reading as returned by the meter.
  typedef struct packed {
    logic [ClockWidth-1:0] freq;
    logic                  err;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  icfm_capture_if cap_if ();
  icfm_cfg_if     cfg_if ();
  icfm_result_if  res_if ();

  input_capture_frequency_meter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .capture_i(cap_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be offered, and readings the meter still owes us.
  capture_t pending_captures[$];
  reading_t expected_readings[$];

  // Our own copy of the meter's state: the timer clock register, whether a
  // first edge is held, and the counter value latched at that edge.
  logic [ClockWidth-1:0]   meter_clock_hz = ClockReset;
  logic                    pair_open      = 1'b0;
  logic [CounterWidth-1:0] first_edge     = '0;

  // Idle behaviour of each side, switched per phase by the stimulus.
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;

  int unsigned failures     = 0;
  int unsigned results_seen = 0;
  int unsigned next_hold_at = FirstHoldAt;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned cycle_count  = 0;

  // Gap length for either side: mostly none or short, occasionally long.
  function automatic int unsigned gap_len(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Works out what an accepted capture request does to the pairing, and
  // queues the reading it causes, if any.
  function automatic void predict_reading(logic [CaptureWidth-1:0] value, logic measured);
    logic [CounterWidth-1:0] edge_count;
    logic [CounterWidth-1:0] period;
    reading_t                reading;
    edge_count = value[CounterWidth-1:0];
    // Requests from other channels leave the pairing untouched.
    if (!measured) return;
    if (!pair_open) begin
      first_edge = edge_count;
      pair_open  = 1'b1;
      return;
    end
    pair_open = 1'b0;
    if (edge_count == first_edge) begin
      // Equal captures cannot give a period, so an error reading is due.
      reading.freq = '0;
      reading.err  = 1'b1;
    end else begin
      // Modular subtraction covers the counter wrapping between the edges.
      period       = edge_count - first_edge;
      reading.freq = meter_clock_hz / ClockWidth'(period);
      reading.err  = 1'b0;
    end
    expected_readings.push_back(reading);
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= MaxReports) $display("ERROR: %s", msg);
  endtask

  // Capture driver. A request is held until it is accepted; after each
  // acceptance a fresh gap is drawn before the next one is offered.
  always @(posedge clk_i) begin : capture_driver
    capture_t    item;
    int unsigned gap;
    bit          accepted;
    if (!rst_ni) begin
      cap_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      accepted = cap_if.valid && cap_if.ready;
      if (accepted) predict_reading(cap_if.capture_value, cap_if.on_measured_channel);
      if (accepted || !cap_if.valid) begin
        gap = accepted ? gap_len(sender_gaps) : gap_left;
        if (gap > 0) begin
          gap_left = gap - 1;
          cap_if.valid <= 1'b0;
        end else if (pending_captures.size() != 0) begin
          item = pending_captures.pop_front();
          cap_if.valid               <= 1'b1;
          cap_if.capture_value       <= item.value;
          cap_if.on_measured_channel <= item.measured;
        end else begin
          cap_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted reading is compared with the oldest one
  // owed; ready is withdrawn at random and, twice in the run, for a long hold.
  always @(posedge clk_i) begin : result_monitor
    reading_t    seen;
    reading_t    want;
    int unsigned stall;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen.freq = res_if.frequency_hz;
        seen.err  = res_if.equal_capture_error;
        results_seen++;
        if (expected_readings.size() == 0) begin
          note_failure($sformatf("reading %0d arrived unexpectedly: freq %0d err %0b",
                                 results_seen, seen.freq, seen.err));
        end else begin
          want = expected_readings.pop_front();
          if (seen.freq !== want.freq || seen.err !== want.err) begin
            note_failure($sformatf("reading %0d: expected freq %0d err %0b, got freq %0d err %0b",
                                   results_seen, want.freq, want.err, seen.freq, seen.err));
          end
        end
        if (results_seen == next_hold_at && next_hold_at < FirstHoldAt + 2 * HoldSpacing) begin
          stall_left   = LongHoldCycles;
          next_hold_at = next_hold_at + HoldSpacing;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        stall = gap_len(receiver_gaps);
        if (stall > 0) begin
          stall_left = stall - 1;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog against a meter that stops answering.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_capture(logic [CaptureWidth-1:0] value, logic measured);
    capture_t item;
    item.value    = value;
    item.measured = measured;
    pending_captures.push_back(item);
  endtask

  task automatic push_pair(logic [CaptureWidth-1:0] first, logic [CaptureWidth-1:0] second);
    push_capture(first, 1'b1);
    push_capture(second, 1'b1);
  endtask

  // Waits until every request has gone in and every reading has come back,
  // then lets the meter settle so that it is idle for a register write.
  task automatic wait_for_drain();
    @(posedge clk_i);
    while (pending_captures.size() != 0 || cap_if.valid || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timer_clock(logic [ClockWidth-1:0] hz);
    @(posedge clk_i);
    cfg_if.valid          <= 1'b1;
    cfg_if.timer_clock_hz <= hz;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid   <= 1'b0;
    meter_clock_hz = hz;
  endtask

  // Random measured edges, mostly in well-formed pairs with a spread of
  // periods, with requests from other channels and lone edges mixed in.
  task automatic push_random_edges(int unsigned count);
    int unsigned             pushed;
    int unsigned             r;
    logic [CaptureWidth-1:0] first;
    logic [CaptureWidth-1:0] delta;
    pushed = 0;
    while (pushed < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_capture(CaptureWidth'($urandom), 1'b0);
      end else if (r < 12) begin
        // A lone edge shifts the pairing of everything that follows.
        push_capture(CaptureWidth'($urandom), 1'b1);
        pushed++;
      end else begin
        first = CaptureWidth'($urandom);
        r     = $urandom_range(0, 99);
        if (r < 8)       delta = '0;
        else if (r < 40) delta = CaptureWidth'($urandom_range(1, 16));
        else if (r < 55) delta = CaptureWidth'($urandom_range(65520, 65535));
        else             delta = CaptureWidth'($urandom_range(1, 65535));
        push_capture(first, 1'b1);
        if ($urandom_range(0, 9) == 0) push_capture(CaptureWidth'($urandom), 1'b0);
        push_capture(first + delta, 1'b1);
        pushed += 2;
      end
    end
  endtask

  initial begin : stimulus
    logic [ClockWidth-1:0] phase_clock;
    cap_if.valid               = 1'b0;
    cap_if.capture_value       = '0;
    cap_if.on_measured_channel = 1'b0;
    res_if.ready               = 1'b0;
    cfg_if.valid               = 1'b0;
    cfg_if.timer_clock_hz      = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset timer clock of 72 MHz.
    push_capture(16'h1234, 1'b0);    // another channel before any edge
    push_pair(16'h0000, 16'hFFFF);   // longest period without wrap
    push_pair(16'hFFFF, 16'h0000);   // wrap over the top, period of one
    push_pair(16'd100, 16'd100);     // equal captures give the error reading
    push_pair(16'd10, 16'd5);        // wrap with a long period
    push_capture(16'd200, 1'b1);     // opens a pair with another channel inside it
    push_capture(16'd300, 1'b0);
    push_capture(16'd1200, 1'b1);
    push_pair(16'hAAAA, 16'h5555);
    wait_for_drain();

    // Fastest timer clock allowed.
    write_timer_clock(ClockMaxHz);
    push_pair(16'd0, 16'd1);
    push_pair(16'd7, 16'd4);
    wait_for_drain();

    // A zero timer clock divides to zero without raising the error flag.
    write_timer_clock('0);
    push_pair(16'd1, 16'd2);
    push_pair(16'd9, 16'd9);
    wait_for_drain();

    write_timer_clock(ClockWidth'(1));
    push_pair(16'd0, 16'd1);

    // Random phases. Each starts from an idle meter with a new timer clock;
    // waiting for the drain is also where the sender pauses for all readings.
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      wait_for_drain();
      case (phase)
        0: phase_clock = ClockMaxHz;
        1: phase_clock = ClockWidth'(1);
        default: begin
          if ($urandom_range(0, 3) == 0) phase_clock = ClockWidth'($urandom_range(1, 1000));
          else                           phase_clock = ClockWidth'($urandom_range(1, 200000000));
        end
      endcase
      write_timer_clock(phase_clock);
      sender_gaps   = (phase % 4 != 1) && (phase % 4 != 3);
      receiver_gaps = (phase % 4 != 2) && (phase % 4 != 3);
      push_random_edges(PhaseEdges);
    end

    wait_for_drain();
    if (failures == 0 && expected_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### input_capture_frequency_meter.f
rtl/icfm_pkg.sv
rtl/icfm_capture_if.sv
rtl/icfm_result_if.sv
rtl/icfm_cfg_if.sv
rtl/icfm_divider.sv
rtl/input_capture_frequency_meter.sv
verif/input_capture_frequency_meter_tb.sv
